// ===== rtl/core/pmtud_pkg.sv =====
// ----------------------------------------------------------------------------
// pmtud_pkg
// Types, constants and helper functions shared by the path MTU search logic.
// ----------------------------------------------------------------------------
package pmtud_pkg;

   localparam int MtuW    = 11;
   localparam int TimeW   = 48;
   localparam int CsrIdxW = 3;
   localparam int CsrDataW = 32;

   localparam logic [MtuW-1:0] MtuMaxAbs = 11'd1500;
   localparam logic [7:0]      LossThreshold = 8'd3;
   localparam logic [15:0]     LossWindowMs  = 16'd3000;
   localparam logic [15:0]     CooldownMs    = 16'd5000;
   localparam logic [15:0]     DefaultStep    = 16'd16;
   localparam logic [15:0]     DefaultTimeout = 16'd2000;
   localparam logic [31:0]     MinInterval    = 32'd1000;

   // ladder rungs
   localparam logic [MtuW-1:0] Rung0 = 11'd1380;
   localparam logic [MtuW-1:0] Rung1 = 11'd1450;
   localparam logic [MtuW-1:0] Rung2 = 11'd1492;
   localparam logic [MtuW-1:0] Rung3 = 11'd1500;

   // register reset values
   localparam logic [MtuW-1:0] ResetFloor = 11'd576;
   localparam logic [MtuW-1:0] ResetTop   = 11'd1500;
   localparam logic [MtuW-1:0] ResetStart = 11'd1400;
   localparam logic [31:0]     ResetInterval = 32'd300000;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_ENABLE   = 3'd0,
      CSR_IPV6     = 3'd1,
      CSR_FLOOR    = 3'd2,
      CSR_TOP      = 3'd3,
      CSR_START    = 3'd4,
      CSR_STEP     = 3'd5,
      CSR_TIMEOUT  = 3'd6,
      CSR_INTERVAL = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      FN_VALIDATED  = 3'd0,
      FN_QUERY      = 3'd1,
      FN_PROBE_SENT = 3'd2,
      FN_PROBE_ACK  = 3'd3,
      FN_PROBE_LOST = 3'd4,
      FN_TIMEOUT    = 3'd5,
      FN_DATA_ACK   = 3'd6,
      FN_DATA_LOSS  = 3'd7
   } func_type;

   typedef enum logic [1:0] {
      PH_LADDER = 2'd0,
      PH_BINARY = 2'd1,
      PH_STABLE = 2'd2
   } phase_type;

   typedef struct packed {
      logic            enable;
      logic            ipv6;
      logic [MtuW-1:0] mtu_floor;
      logic [MtuW-1:0] mtu_top;
      logic [MtuW-1:0] mtu_start;
      logic [15:0]     search_step;
      logic [15:0]     probe_timeout_ms;
      logic [31:0]     reprobe_interval_ms;
   } cfg_type;

   typedef struct packed {
      logic [MtuW-1:0]  committed_mtu;
      logic [MtuW-1:0]  ceiling_mtu;
      logic [MtuW-1:0]  window_low;
      logic [MtuW-1:0]  window_high;
      phase_type        search_phase;
      logic [TimeW-1:0] next_probe_time;
      logic [TimeW-1:0] last_big_ack_time;
      logic [TimeW-1:0] last_big_loss_time;
      logic [TimeW-1:0] cooldown_until;
      logic [7:0]       loss_streak;
      logic             probe_in_flight;
      logic [31:0]      flight_packet_number;
      logic [MtuW-1:0]  flight_mtu;
      logic [TimeW-1:0] flight_deadline;
   } state_type;

   typedef struct packed {
      logic [2:0]       func;
      logic [TimeW-1:0] now_ms;
      logic [31:0]      packet_number;
      logic [15:0]      probe_size;
      logic [15:0]      data_size;
   } item_type;

   typedef struct packed {
      logic            accepted;
      logic            probe_due;
      logic [MtuW-1:0] next_probe_mtu;
      logic [MtuW-1:0] current_mtu;
      logic [MtuW-1:0] current_payload_max;
      logic [MtuW-1:0] ceiling_payload_max;
      logic [1:0]      phase;
   } result_type;

   function automatic logic [MtuW-1:0] clamp_mtu(input logic [MtuW-1:0] v,
                                                 input logic [MtuW-1:0] lo,
                                                 input logic [MtuW-1:0] hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic logic [MtuW-1:0] payload_of(input logic [MtuW-1:0] mtu,
                                                  input logic ipv6);
      logic [MtuW-1:0] ov;
      ov = ipv6 ? 11'd48 : 11'd28;
      return (mtu <= ov) ? '0 : mtu - ov;
   endfunction

   // first rung inside the window, otherwise the window low
   function automatic logic [MtuW-1:0] ladder_target(input logic [MtuW-1:0] wl,
                                                     input logic [MtuW-1:0] ceil,
                                                     input logic [MtuW-1:0] top,
                                                     input logic [MtuW-1:0] flo);
      logic [MtuW-1:0] r;
      logic [MtuW-1:0] res;
      res = wl;
      for (int i = 3; i >= 0; i--) begin
         case (i)
            0:       r = Rung0;
            1:       r = Rung1;
            2:       r = Rung2;
            default: r = Rung3;
         endcase
         if (r > wl && r <= ceil && r <= top && r >= flo) res = r;
      end
      return res;
   endfunction

   function automatic logic [MtuW-1:0] binary_target(input logic [MtuW-1:0] wl,
                                                     input logic [MtuW-1:0] wh,
                                                     input logic [15:0] step);
      logic [MtuW:0] lo;
      logic [MtuW:0] diff;
      if ({6'd0, wh} <= {6'd0, wl} + {1'b0, step}) return wl;
      lo = {1'b0, wl} + 12'd1;
      if (lo >= {1'b0, wh}) return wl;
      diff = {1'b0, wh} - lo;
      return MtuW'(lo + (diff >> 1));
   endfunction

endpackage

// ===== rtl/core/pmtud_chan_if.sv =====
// ----------------------------------------------------------------------------
// pmtud_req_if / pmtud_rsp_if
// Valid/ready channels for events in and results out.
// ----------------------------------------------------------------------------
interface pmtud_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  func;
   logic [47:0] now_ms;
   logic [31:0] packet_number;
   logic [15:0] probe_size;
   logic [15:0] data_size;

   modport source (output valid, func, now_ms, packet_number, probe_size, data_size,
                   input ready);
   modport sink (input valid, func, now_ms, packet_number, probe_size, data_size,
                 output ready);
endinterface

interface pmtud_rsp_if;
   logic        valid;
   logic        ready;
   logic        accepted;
   logic        probe_due;
   logic [10:0] next_probe_mtu;
   logic [10:0] current_mtu;
   logic [10:0] current_payload_max;
   logic [10:0] ceiling_payload_max;
   logic [1:0]  phase;

   modport source (output valid, accepted, probe_due, next_probe_mtu, current_mtu,
                   current_payload_max, ceiling_payload_max, phase, input ready);
   modport sink (input valid, accepted, probe_due, next_probe_mtu, current_mtu,
                 current_payload_max, ceiling_payload_max, phase, output ready);
endinterface

// ===== rtl/core/pmtud_step.sv =====
// ----------------------------------------------------------------------------
// pmtud_step
// Applies one event to the search state and forms the result of that event.
// ----------------------------------------------------------------------------
module pmtud_step (
   input  pmtud_pkg::cfg_type    cfg,
   input  pmtud_pkg::state_type  cur,
   input  pmtud_pkg::item_type   item,
   output pmtud_pkg::state_type  nxt,
   output pmtud_pkg::result_type res
);
   import pmtud_pkg::*;

   logic [MtuW-1:0]  min_sup, eff_floor, eff_top, eff_start;
   logic [15:0]      eff_step, eff_timeout;
   logic [31:0]      eff_interval;
   logic [TimeW-1:0] now;
   logic [MtuW-1:0]  cur_payload;
   logic             big_data;
   logic             step_acc;

   // effective register values
   always_comb begin
      min_sup      = cfg.ipv6 ? 11'd69 : 11'd49;
      eff_floor    = clamp_mtu(cfg.mtu_floor, min_sup, MtuMaxAbs);
      eff_top      = clamp_mtu(cfg.mtu_top, eff_floor, MtuMaxAbs);
      eff_start    = clamp_mtu(cfg.mtu_start, eff_floor, eff_top);
      eff_step     = (cfg.search_step == '0) ? DefaultStep : cfg.search_step;
      eff_timeout  = (cfg.probe_timeout_ms == '0) ? DefaultTimeout : cfg.probe_timeout_ms;
      eff_interval = (cfg.reprobe_interval_ms < MinInterval) ? MinInterval
                                                             : cfg.reprobe_interval_ms;
      now          = item.now_ms;
      cur_payload  = payload_of(cur.committed_mtu, cfg.ipv6);
      big_data     = cfg.enable &&
                     ({1'b0, item.data_size} + {1'b0, eff_step} >= {6'd0, cur_payload});
   end

   // event update
   always_comb begin
      state_type        s;
      logic             acc;
      logic [MtuW-1:0]  cp, lt, nh;
      logic [MtuW:0]    lo1;
      logic             ack_recent;
      logic             lost;
      s    = cur;
      acc  = 1'b0;
      cp   = '0;
      lt   = '0;
      nh   = '0;
      lost = 1'b0;
      lo1  = {1'b0, cur.window_low} + 12'd1;
      ack_recent = 1'b0;
      case (func_type'(item.func))
         FN_VALIDATED: begin
            s.committed_mtu      = eff_start;
            s.last_big_ack_time  = '0;
            s.last_big_loss_time = '0;
            s.cooldown_until     = '0;
            s.loss_streak        = '0;
            s.probe_in_flight    = 1'b0;
            s.flight_packet_number = '0;
            s.flight_mtu         = '0;
            s.flight_deadline    = '0;
            s.ceiling_mtu        = cfg.enable ? eff_top : eff_start;
            s.window_low         = eff_start;
            s.window_high        = s.ceiling_mtu;
            s.search_phase       = cfg.enable ? PH_LADDER : PH_STABLE;
            s.next_probe_time    = now;
            acc = 1'b1;
         end
         FN_QUERY: begin
            acc = 1'b0; // filled from probe_due by the controller
         end
         FN_PROBE_SENT: begin
            if (cfg.enable && item.packet_number != '0) begin
               // lower bound first, then ceiling
               if (item.probe_size < {4'd0, lo1}) cp = MtuW'(lo1);
               else if (item.probe_size > {5'd0, cur.ceiling_mtu}) cp = cur.ceiling_mtu;
               else cp = MtuW'(item.probe_size);
               if ({4'd0, lo1} > {5'd0, cur.ceiling_mtu} && {1'b0, cp} != lo1)
                  cp = cur.ceiling_mtu;
               if ({1'b0, cp} >= lo1 && cp > cur.window_low) begin
                  lt = ladder_target(cur.window_low, cur.ceiling_mtu, eff_top, eff_floor);
                  s.probe_in_flight = 1'b1;
                  if (cur.search_phase == PH_LADDER && (lt == cur.window_low || cp != lt))
                     s.search_phase = PH_BINARY;
                  s.flight_packet_number = item.packet_number;
                  s.flight_mtu      = cp;
                  s.flight_deadline = now + {32'd0, eff_timeout};
                  acc = 1'b1;
               end
            end
         end
         FN_PROBE_ACK: begin
            if (cur.probe_in_flight && item.packet_number == cur.flight_packet_number) begin
               if (cur.flight_mtu > cur.window_low) s.window_low = cur.flight_mtu;
               s.last_big_ack_time = now;
               s.loss_streak       = '0;
               s.probe_in_flight   = 1'b0;
               s.flight_packet_number = '0;
               s.flight_mtu        = '0;
               s.flight_deadline   = '0;
               if (s.search_phase == PH_LADDER &&
                   ladder_target(s.window_low, s.ceiling_mtu, eff_top, eff_floor)
                      <= s.window_low)
                  s.search_phase = PH_BINARY;
               if (s.window_low >= eff_top) begin
                  s.committed_mtu   = eff_top;
                  s.ceiling_mtu     = eff_top;
                  s.window_low      = eff_top;
                  s.window_high     = eff_top;
                  s.search_phase    = PH_STABLE;
                  s.next_probe_time = now + {16'd0, eff_interval};
               end else if (s.search_phase == PH_BINARY &&
                            {6'd0, s.window_high} <=
                            {6'd0, s.window_low} + {1'b0, eff_step}) begin
                  s.committed_mtu   = s.window_low;
                  s.ceiling_mtu     = s.window_low;
                  s.search_phase    = PH_STABLE;
                  s.next_probe_time = now + {16'd0, eff_interval};
               end else begin
                  s.next_probe_time = now + 48'd1;
               end
               acc = 1'b1;
            end
         end
         FN_PROBE_LOST: begin
            lost = cur.probe_in_flight && item.packet_number == cur.flight_packet_number;
         end
         FN_TIMEOUT: begin
            lost = cur.probe_in_flight && now >= cur.flight_deadline;
         end
         FN_DATA_ACK: begin
            if (big_data) begin
               s.last_big_ack_time = now;
               s.loss_streak       = '0;
               acc = 1'b1;
            end
         end
         default: begin
            if (big_data) begin
               if (cur.last_big_loss_time == '0 ||
                   {1'b0, now} > {1'b0, cur.last_big_loss_time} + {33'd0, LossWindowMs})
                  s.loss_streak = '0;
               s.last_big_loss_time = now;
               if (s.loss_streak != 8'hFF) s.loss_streak = s.loss_streak + 8'd1;
               ack_recent = cur.last_big_ack_time != '0 &&
                            {1'b0, now} <= {1'b0, cur.last_big_ack_time} +
                                           {32'd0, eff_timeout, 1'b0};
               if (s.loss_streak >= LossThreshold && !ack_recent) begin
                  // blackhole: fall back to the floor and restart the search
                  s.committed_mtu   = eff_floor;
                  s.ceiling_mtu     = eff_top;
                  s.search_phase    = PH_LADDER;
                  s.window_low      = eff_floor;
                  s.window_high     = eff_top;
                  s.probe_in_flight = 1'b0;
                  s.flight_packet_number = '0;
                  s.flight_mtu      = '0;
                  s.flight_deadline = '0;
                  s.cooldown_until  = now + {32'd0, CooldownMs};
                  s.next_probe_time = s.cooldown_until;
                  s.loss_streak     = '0;
                  acc = 1'b1;
               end
            end
         end
      endcase

      // lost probe lowers the ceiling
      if (lost) begin
         if (cur.flight_mtu != '0) begin
            nh = cur.flight_mtu - 11'd1;
            if (nh < s.window_high) s.window_high = nh;
            if (s.window_high < s.ceiling_mtu) s.ceiling_mtu = s.window_high;
            s.search_phase = PH_BINARY;
         end
         s.probe_in_flight = 1'b0;
         s.flight_packet_number = '0;
         s.flight_mtu      = '0;
         s.flight_deadline = '0;
         if ({6'd0, s.window_high} <= {6'd0, s.window_low} + {1'b0, eff_step}) begin
            s.committed_mtu   = s.window_low;
            s.ceiling_mtu     = s.window_low;
            s.search_phase    = PH_STABLE;
            s.next_probe_time = now + {16'd0, eff_interval};
         end else begin
            s.next_probe_time = now + 48'd1;
         end
         acc = 1'b1;
      end

      nxt      = s;
      step_acc = acc;
   end

   // result from the updated state
   always_comb begin
      logic [MtuW-1:0] np, lt2, bt2;
      lt2 = ladder_target(nxt.window_low, nxt.ceiling_mtu, eff_top, eff_floor);
      bt2 = binary_target(nxt.window_low, nxt.window_high, eff_step);
      if (!cfg.enable || nxt.window_low >= nxt.ceiling_mtu) np = nxt.window_low;
      else if (nxt.search_phase == PH_LADDER) np = (lt2 > nxt.window_low) ? lt2 : bt2;
      else if (nxt.search_phase == PH_BINARY) np = bt2;
      else np = nxt.window_low;
      res.accepted  = step_acc;
      res.probe_due = cfg.enable && !nxt.probe_in_flight &&
                      now >= nxt.cooldown_until && now >= nxt.next_probe_time &&
                      np > nxt.window_low;
      res.next_probe_mtu      = np;
      res.current_mtu         = nxt.committed_mtu;
      res.current_payload_max = payload_of(nxt.committed_mtu, cfg.ipv6);
      res.ceiling_payload_max = payload_of(nxt.ceiling_mtu, cfg.ipv6);
      res.phase               = nxt.search_phase;
   end

endmodule

// ===== rtl/core/path_mtu_discovery_controller.sv =====
// ----------------------------------------------------------------------------
// path_mtu_discovery_controller
// Packetization-layer path MTU search: ladder climb, binary search and
// blackhole fallback, one result per event.
// ----------------------------------------------------------------------------
//  channel   direction  handshake        payload
//  req_chan  in         valid/ready      func, now_ms, packet_number, sizes
//  rsp_chan  out        valid/ready      accepted, probe_due, MTUs, phase
//  csr_*     in         write enable     index 0..7, 32-bit data
//
// One event per cycle while the result sink does not stall; an event goes
// from the input register through the step logic into the result register,
// and its result is offered from there.
// Reset is synchronous and restores the registers and the search state.
// A stalled result holds the pipe; the input register still takes one event.
module path_mtu_discovery_controller (
   input  logic                              clock,
   input  logic                              reset,
   pmtud_req_if.sink                         req_chan,
   pmtud_rsp_if.source                       rsp_chan,
   input  logic                              csr_we,
   input  logic [pmtud_pkg::CsrIdxW-1:0]     csr_index,
   input  logic [pmtud_pkg::CsrDataW-1:0]    csr_wdata
);
   import pmtud_pkg::*;

   cfg_type    cfg_ff;
   state_type  state_ff, state_in;
   item_type   item_ff;
   logic       item_valid_ff;
   result_type result_ff, result_in;
   logic       rsp_valid_ff;
   logic       advance;
   func_type   item_func_q;

   // pipe control
   assign advance        = item_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !item_valid_ff || advance;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable              <= 1'b1;
         cfg_ff.ipv6                <= 1'b0;
         cfg_ff.mtu_floor           <= ResetFloor;
         cfg_ff.mtu_top             <= ResetTop;
         cfg_ff.mtu_start           <= ResetStart;
         cfg_ff.search_step         <= DefaultStep;
         cfg_ff.probe_timeout_ms    <= DefaultTimeout;
         cfg_ff.reprobe_interval_ms <= ResetInterval;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_ENABLE:   cfg_ff.enable              <= csr_wdata[0];
            CSR_IPV6:     cfg_ff.ipv6                <= csr_wdata[0];
            CSR_FLOOR:    cfg_ff.mtu_floor           <= csr_wdata[MtuW-1:0];
            CSR_TOP:      cfg_ff.mtu_top             <= csr_wdata[MtuW-1:0];
            CSR_START:    cfg_ff.mtu_start           <= csr_wdata[MtuW-1:0];
            CSR_STEP:     cfg_ff.search_step         <= csr_wdata[15:0];
            CSR_TIMEOUT:  cfg_ff.probe_timeout_ms    <= csr_wdata[15:0];
            CSR_INTERVAL: cfg_ff.reprobe_interval_ms <= csr_wdata;
            default:      cfg_ff.enable              <= cfg_ff.enable;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         item_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         item_ff.func          <= req_chan.func;
         item_ff.now_ms        <= req_chan.now_ms;
         item_ff.packet_number <= req_chan.packet_number;
         item_ff.probe_size    <= req_chan.probe_size;
         item_ff.data_size     <= req_chan.data_size;
      end
   end

   pmtud_step u_step (
      .cfg  (cfg_ff),
      .cur  (state_ff),
      .item (item_ff),
      .nxt  (state_in),
      .res  (result_in)
   );

   // search state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.committed_mtu        <= ResetStart;
         state_ff.ceiling_mtu          <= ResetTop;
         state_ff.window_low           <= ResetStart;
         state_ff.window_high          <= ResetTop;
         state_ff.search_phase         <= PH_LADDER;
         state_ff.next_probe_time      <= '0;
         state_ff.last_big_ack_time    <= '0;
         state_ff.last_big_loss_time   <= '0;
         state_ff.cooldown_until       <= '0;
         state_ff.loss_streak          <= '0;
         state_ff.probe_in_flight      <= 1'b0;
         state_ff.flight_packet_number <= '0;
         state_ff.flight_mtu           <= '0;
         state_ff.flight_deadline      <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   // function code of the event held in the result register
   always_ff @(posedge clock) begin
      if (advance) begin
         item_func_q <= func_type'(item_ff.func);
      end
   end

   assign rsp_chan.valid               = rsp_valid_ff;
   assign rsp_chan.accepted            = result_ff.accepted | (result_ff.probe_due &
                                         (item_func_q == FN_QUERY));
   assign rsp_chan.probe_due           = result_ff.probe_due;
   assign rsp_chan.next_probe_mtu      = result_ff.next_probe_mtu;
   assign rsp_chan.current_mtu         = result_ff.current_mtu;
   assign rsp_chan.current_payload_max = result_ff.current_payload_max;
   assign rsp_chan.ceiling_payload_max = result_ff.ceiling_payload_max;
   assign rsp_chan.phase               = result_ff.phase;

endmodule

// ===== sim/tb_path_mtu_discovery_controller.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_path_mtu_discovery_controller
// Self-checking bench for the path MTU search block. Event items are driven in
// random bursts, and each transfer is run through a local copy of the search
// state to work out its result. Results coming back through a stalling sink
// are compared field by field with the oldest outstanding prediction. The run
// goes through several register settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb_path_mtu_discovery_controller;
   import pmtud_pkg::*;

   localparam longint unsigned Mask48 = 64'hFFFF_FFFF_FFFF;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CsrIdxW-1:0]  csr_index;
   logic [CsrDataW-1:0] csr_wdata;

   pmtud_req_if req_chan ();
   pmtud_rsp_if rsp_chan ();

   path_mtu_discovery_controller dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // pending events, predicted results, bookkeeping
   item_type   event_queue[$];
   result_type result_queue[$];
   item_type   driven_item;
   int         errors = 0;
   int         events_done = 0;
   int         results_done = 0;
   int         hold_asked = 0;
   int         hold_served = 0;

   // local copy of registers and search state
   bit               c_en, c_v6;
   int unsigned      c_floor, c_top, c_start, c_step, c_tmo, c_ivl;
   int unsigned      cm, ceil_m, wlo, whi, streak, fl_pn, fl_mtu;
   phase_type        ph;
   bit               in_fl;
   longint unsigned  t_next, t_ack, t_loss, t_cool, fl_dl;

   // stimulus generator state
   longint unsigned  gen_now;
   int unsigned      gen_pn;

   // ------------------------------------------------------------------------
   // search state predictor
   // ------------------------------------------------------------------------
   function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int unsigned overhead();
      return c_v6 ? 48 : 28;
   endfunction

   function automatic int unsigned floor_eff();
      return clip(c_floor, overhead() + 21, 1500);
   endfunction

   function automatic int unsigned top_eff();
      return clip(c_top, floor_eff(), 1500);
   endfunction

   function automatic int unsigned start_eff();
      return clip(c_start, floor_eff(), top_eff());
   endfunction

   function automatic int unsigned step_eff();
      return (c_step != 0) ? c_step : 16;
   endfunction

   function automatic int unsigned tmo_eff();
      return (c_tmo != 0) ? c_tmo : 2000;
   endfunction

   function automatic int unsigned ivl_eff();
      return (c_ivl < 1000) ? 1000 : c_ivl;
   endfunction

   function automatic int unsigned payload(int unsigned m);
      return (m <= overhead()) ? 0 : m - overhead();
   endfunction

   function automatic int unsigned ladder_pick();
      int unsigned rungs[4];
      rungs = '{Rung0, Rung1, Rung2, Rung3};
      foreach (rungs[i]) begin
         if (rungs[i] <= wlo || rungs[i] > ceil_m || rungs[i] > top_eff() ||
             rungs[i] < floor_eff()) continue;
         return rungs[i];
      end
      return wlo;
   endfunction

   function automatic int unsigned binary_pick();
      int unsigned lo, mid;
      if (whi <= wlo + step_eff()) return wlo;
      lo = wlo + 1;
      if (lo >= whi) return wlo;
      mid = lo + (whi - lo) / 2;
      if (mid <= wlo) return wlo;
      return clip(mid, lo, whi);
   endfunction

   function automatic int unsigned probe_pick();
      int unsigned c;
      if (!c_en || wlo >= ceil_m) return wlo;
      if (ph == PH_LADDER) begin
         c = ladder_pick();
         if (c > wlo) return c;
         c = binary_pick();
         return (c > wlo) ? c : wlo;
      end
      if (ph == PH_BINARY) begin
         c = binary_pick();
         if (c > wlo) return c;
      end
      return wlo;
   endfunction

   function automatic bit probe_wanted(longint unsigned now);
      if (!c_en || in_fl) return 0;
      if (now < t_cool || now < t_next) return 0;
      return probe_pick() > wlo;
   endfunction

   function automatic void drop_flight();
      in_fl = 0;
      fl_pn = 0;
      fl_mtu = 0;
      fl_dl = 0;
   endfunction

   function automatic void settle(longint unsigned now);
      cm = wlo;
      ceil_m = wlo;
      ph = PH_STABLE;
      t_next = (now + ivl_eff()) & Mask48;
   endfunction

   function automatic void lose_probe(longint unsigned now);
      if (fl_mtu > 0) begin
         if (fl_mtu - 1 < whi) whi = fl_mtu - 1;
         if (whi < ceil_m) ceil_m = whi;
         ph = PH_BINARY;
      end
      drop_flight();
      if (whi <= wlo + step_eff()) settle(now);
      else t_next = (now + 1) & Mask48;
   endfunction

   function automatic void restart_search();
      cm = start_eff();
      ceil_m = top_eff();
      wlo = cm;
      whi = ceil_m;
      ph = PH_LADDER;
      t_next = 0;
      t_ack = 0;
      t_loss = 0;
      t_cool = 0;
      streak = 0;
      drop_flight();
   endfunction

   function automatic result_type predict_event(item_type it);
      result_type      r;
      bit              acc;
      longint unsigned now;
      int unsigned     cp, lt;
      acc = 0;
      now = it.now_ms;
      case (func_type'(it.func))
         FN_VALIDATED: begin
            cm = start_eff();
            t_ack = 0;
            t_loss = 0;
            t_cool = 0;
            streak = 0;
            drop_flight();
            ceil_m = c_en ? top_eff() : cm;
            wlo = cm;
            whi = ceil_m;
            ph = c_en ? PH_LADDER : PH_STABLE;
            t_next = now;
            acc = 1;
         end
         FN_QUERY: acc = probe_wanted(now);
         FN_PROBE_SENT: begin
            if (c_en && it.packet_number != 0) begin
               cp = clip(it.probe_size, wlo + 1, ceil_m);
               if (cp > wlo) begin
                  lt = ladder_pick();
                  in_fl = 1;
                  if (ph == PH_LADDER && (lt == wlo || cp != lt)) ph = PH_BINARY;
                  fl_pn = it.packet_number;
                  fl_mtu = cp & 11'h7FF;
                  fl_dl = (now + tmo_eff()) & Mask48;
                  acc = 1;
               end
            end
         end
         FN_PROBE_ACK: begin
            if (in_fl && it.packet_number == fl_pn) begin
               if (fl_mtu > wlo) wlo = fl_mtu;
               t_ack = now;
               streak = 0;
               drop_flight();
               if (ph == PH_LADDER && ladder_pick() <= wlo) ph = PH_BINARY;
               if (wlo >= top_eff()) begin
                  cm = top_eff();
                  ceil_m = cm;
                  wlo = cm;
                  whi = cm;
                  ph = PH_STABLE;
                  t_next = (now + ivl_eff()) & Mask48;
               end else if (ph == PH_BINARY && whi <= wlo + step_eff()) begin
                  settle(now);
               end else begin
                  t_next = (now + 1) & Mask48;
               end
               acc = 1;
            end
         end
         FN_PROBE_LOST: begin
            if (in_fl && it.packet_number == fl_pn) begin
               lose_probe(now);
               acc = 1;
            end
         end
         FN_TIMEOUT: begin
            if (in_fl && now >= fl_dl) begin
               lose_probe(now);
               acc = 1;
            end
         end
         FN_DATA_ACK: begin
            if (c_en && it.data_size + step_eff() >= payload(cm)) begin
               t_ack = now;
               streak = 0;
               acc = 1;
            end
         end
         default: begin
            if (c_en && it.data_size + step_eff() >= payload(cm)) begin
               if (t_loss == 0 || now > t_loss + LossWindowMs) streak = 0;
               t_loss = now;
               if (streak < 255) streak++;
               if (streak >= LossThreshold &&
                   !(t_ack != 0 && now <= t_ack + 2 * longint'(tmo_eff()))) begin
                  // blackhole: fall back to the floor and cool down
                  cm = floor_eff();
                  ceil_m = top_eff();
                  ph = PH_LADDER;
                  wlo = cm;
                  whi = ceil_m;
                  drop_flight();
                  t_cool = (now + CooldownMs) & Mask48;
                  t_next = t_cool;
                  streak = 0;
                  acc = 1;
               end
            end
         end
      endcase
      r.accepted            = acc;
      r.probe_due           = probe_wanted(now);
      r.next_probe_mtu      = MtuW'(probe_pick());
      r.current_mtu         = MtuW'(cm);
      r.current_payload_max = MtuW'(payload(cm));
      r.ceiling_payload_max = MtuW'(payload(ceil_m));
      r.phase               = ph;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // clock, limit
   // ------------------------------------------------------------------------
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("DONE: errors detected");
      $finish;
   end

   // ------------------------------------------------------------------------
   // event driver: bursts of random length with random gaps
   // ------------------------------------------------------------------------
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            result_queue.push_back(predict_event(driven_item));
            events_done++;
         end
         if (req_chan.valid && !req_chan.ready) begin
            // hold the offered event
         end else if (gap_left > 0) begin
            gap_left--;
            req_chan.valid <= 0;
         end else if (event_queue.size() > 0) begin
            driven_item = event_queue.pop_front();
            req_chan.valid         <= 1;
            req_chan.func          <= driven_item.func;
            req_chan.now_ms        <= driven_item.now_ms;
            req_chan.packet_number <= driven_item.packet_number;
            req_chan.probe_size    <= driven_item.probe_size;
            req_chan.data_size     <= driven_item.data_size;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
               gap_left   = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_chan.valid <= 0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // result sink: randomly chosen stall patterns, plus long holds
   // ------------------------------------------------------------------------
   int unsigned sink_cycle = 0;
   int unsigned sink_mode  = 0;
   int          hold_cnt   = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 0;
      end else begin
         sink_cycle++;
         if (sink_cycle % 64 == 0) sink_mode = $urandom_range(0, 3);
         if (hold_asked != hold_served) begin
            hold_served = hold_asked;
            hold_cnt = 300;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_chan.ready <= 0;
         end else begin
            case (sink_mode)
               0:       rsp_chan.ready <= 1;
               1:       rsp_chan.ready <= $urandom_range(0, 1);
               2:       rsp_chan.ready <= (sink_cycle % 4 == 0);
               default: rsp_chan.ready <= $urandom_range(0, 7) != 0;
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // result monitor
   // ------------------------------------------------------------------------
   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         results_done++;
         if (result_queue.size() == 0) begin
            $error("result transfer with no event outstanding");
            errors++;
         end else begin
            want = result_queue.pop_front();
            check_field("accepted", want.accepted, rsp_chan.accepted);
            check_field("probe_due", want.probe_due, rsp_chan.probe_due);
            check_field("next_probe_mtu", want.next_probe_mtu, rsp_chan.next_probe_mtu);
            check_field("current_mtu", want.current_mtu, rsp_chan.current_mtu);
            check_field("current_payload_max", want.current_payload_max,
                        rsp_chan.current_payload_max);
            check_field("ceiling_payload_max", want.ceiling_payload_max,
                        rsp_chan.ceiling_payload_max);
            check_field("phase", want.phase, rsp_chan.phase);
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   task automatic add_event(func_type f, int unsigned pn, int unsigned psize,
                            int unsigned dsize);
      item_type it;
      gen_now = (gen_now + $urandom_range(0, 40)) & Mask48;
      it.func          = f;
      it.now_ms        = TimeW'(gen_now);
      it.packet_number = pn;
      it.probe_size    = 16'(psize);
      it.data_size     = 16'(dsize);
      event_queue.push_back(it);
   endtask

   task automatic csr_write(csr_index_type idx, logic [31:0] val);
      @(posedge clock);
      csr_we    <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_ENABLE:   c_en    = val[0];
         CSR_IPV6:     c_v6    = val[0];
         CSR_FLOOR:    c_floor = val[10:0];
         CSR_TOP:      c_top   = val[10:0];
         CSR_START:    c_start = val[10:0];
         CSR_STEP:     c_step  = val[15:0];
         CSR_TIMEOUT:  c_tmo   = val[15:0];
         default:      c_ivl   = val;
      endcase
      @(posedge clock);
      csr_we <= 0;
   endtask

   task automatic set_all(bit en, bit v6, int unsigned flo, int unsigned top,
                          int unsigned start, int unsigned step, int unsigned tmo,
                          logic [31:0] ivl);
      csr_write(CSR_ENABLE, 32'(en));
      csr_write(CSR_IPV6, 32'(v6));
      csr_write(CSR_FLOOR, flo);
      csr_write(CSR_TOP, top);
      csr_write(CSR_START, start);
      csr_write(CSR_STEP, step);
      csr_write(CSR_TIMEOUT, tmo);
      csr_write(CSR_INTERVAL, ivl);
   endtask

   // sender pauses here until every result is back, then the pipe settles
   task automatic drain();
      while (event_queue.size() != 0 || req_chan.valid || result_queue.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic int unsigned pick_probe_size();
      case ($urandom_range(0, 5))
         0:       return Rung0 + 70 * $urandom_range(0, 1);
         1:       return $urandom_range(1, 3) == 1 ? Rung2 : Rung3;
         2:       return $urandom_range(0, 65535);
         default: return $urandom_range(500, 1500);
      endcase
   endfunction

   task automatic random_events(int count);
      int          n, k, kind;
      int unsigned pn;
      n = 0;
      while (n < count) begin
         kind = $urandom_range(0, 99);
         if (kind < 50) begin
            // probe exchange, sometimes with a loss, a wrong number or a timeout
            gen_pn++;
            pn = gen_pn;
            if ($urandom_range(0, 15) == 0) pn = 0;
            add_event(FN_QUERY, 0, 0, 0);
            add_event(FN_PROBE_SENT, pn, pick_probe_size(), 0);
            case ($urandom_range(0, 5))
               0, 1, 2: add_event(FN_PROBE_ACK, pn, 0, 0);
               3:       add_event(FN_PROBE_LOST, pn, 0, 0);
               4: begin
                  add_event(FN_TIMEOUT, 0, 0, 0);
                  gen_now = (gen_now + tmo_eff() + $urandom_range(0, 50)) & Mask48;
                  add_event(FN_TIMEOUT, 0, 0, 0);
               end
               default: add_event(FN_PROBE_ACK, $urandom, 0, 0);
            endcase
            n += 4;
         end else if (kind < 57) begin
            add_event(FN_VALIDATED, 0, 0, 0);
            n++;
         end else if (kind < 80) begin
            // run of large losses, at times with a recent large ack
            if ($urandom_range(0, 2) == 0) add_event(FN_DATA_ACK, 0, 0, $urandom_range(1300, 1500));
            gen_now += $urandom_range(0, 6000);
            for (k = 0; k < $urandom_range(2, 5); k++) begin
               gen_now += $urandom_range(0, 3500);
               add_event(FN_DATA_LOSS, 0, 0, $urandom_range(1200, 1500));
               n++;
            end
         end else if (kind < 90) begin
            add_event($urandom_range(0, 1) ? FN_DATA_ACK : FN_DATA_LOSS, 0, 0,
                      $urandom_range(0, 1500));
            n++;
         end else begin
            // noise, occasionally with a jump of the clock anywhere in range
            if ($urandom_range(0, 4) == 0)
               gen_now = {$urandom_range(0, 65535), $urandom} & Mask48;
            add_event(func_type'($urandom_range(0, 7)), $urandom, $urandom_range(0, 65535),
                      $urandom_range(0, 65535));
            n++;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin
      int k;
      reset = 1;
      csr_we = 0;
      csr_index = CSR_ENABLE;
      csr_wdata = 0;
      req_chan.valid = 0;
      req_chan.func = FN_QUERY;
      req_chan.now_ms = 0;
      req_chan.packet_number = 0;
      req_chan.probe_size = 0;
      req_chan.data_size = 0;
      rsp_chan.ready = 0;
      c_en = 1; c_v6 = 0; c_floor = ResetFloor; c_top = ResetTop; c_start = ResetStart;
      c_step = DefaultStep; c_tmo = DefaultTimeout; c_ivl = ResetInterval;
      restart_search();
      gen_now = 0;
      gen_pn = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: the ladder, rejections, a timeout and a blackhole
      add_event(FN_QUERY, 0, 0, 0);
      add_event(FN_VALIDATED, 0, 0, 0);
      add_event(FN_QUERY, 0, 0, 0);
      add_event(FN_PROBE_SENT, 1, Rung0, 0);
      add_event(FN_PROBE_ACK, 7, 0, 0);
      add_event(FN_PROBE_ACK, 1, 0, 0);
      add_event(FN_PROBE_SENT, 0, Rung1, 0);
      add_event(FN_PROBE_SENT, 2, 0, 0);
      add_event(FN_PROBE_LOST, 2, 0, 0);
      add_event(FN_PROBE_LOST, 2, 0, 0);
      add_event(FN_PROBE_SENT, 32'hFFFF_FFFF, 16'hFFFF, 0);
      add_event(FN_TIMEOUT, 0, 0, 0);
      gen_now += 2500;
      add_event(FN_TIMEOUT, 0, 0, 0);
      add_event(FN_TIMEOUT, 0, 0, 0);
      add_event(FN_DATA_ACK, 0, 0, 0);
      add_event(FN_DATA_ACK, 0, 0, 16'hFFFF);
      gen_now += 10000;
      for (k = 0; k < 3; k++) add_event(FN_DATA_LOSS, 0, 0, 1400);
      add_event(FN_QUERY, 0, 0, 0);
      gen_now = Mask48 - 30;
      add_event(FN_VALIDATED, 0, 0, 0);
      add_event(FN_PROBE_SENT, 9, Rung0, 0);
      add_event(FN_TIMEOUT, 0, 0, 0);
      drain();

      set_all(1, 0, ResetFloor, ResetTop, ResetStart, DefaultStep, DefaultTimeout,
              ResetInterval);
      gen_now = 1000;
      add_event(FN_VALIDATED, 0, 0, 0);
      random_events(280);
      hold_asked++;
      drain();

      // zeros: defaults for step and timeout, minimum interval, lowest floor
      set_all(1, 1, 0, 1500, 0, 0, 0, 0);
      add_event(FN_VALIDATED, 0, 0, 0);
      random_events(280);
      drain();

      // maxima, with a long run of losses that pushes the streak to saturation
      set_all(1, 1, 1500, 0, 1500, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      add_event(FN_VALIDATED, 0, 0, 0);
      add_event(FN_DATA_ACK, 0, 0, 1500);
      for (k = 0; k < 270; k++) add_event(FN_DATA_LOSS, 0, 0, 1500);
      random_events(150);
      hold_asked++;
      drain();

      // discovery off
      set_all(0, 0, 1000, 1400, 1200, 8, 500, 2000);
      add_event(FN_VALIDATED, 0, 0, 0);
      random_events(200);
      drain();

      // narrow window, smallest step and timeout
      set_all(1, 0, 1200, 1480, 1300, 1, 1, 1000);
      add_event(FN_VALIDATED, 0, 0, 0);
      random_events(280);
      drain();

      // all-ones floor, top and start values, clamped by the block
      set_all(1, 0, 11'h7FF, 11'h7FF, 11'h7FF, 100, 300, 5000);
      add_event(FN_VALIDATED, 0, 0, 0);
      random_events(100);
      drain();
      set_all(1, 0, 600, 1500, 700, 40, 300, 5000);
      add_event(FN_VALIDATED, 0, 0, 0);
      random_events(150);
      drain();
      repeat (20) @(posedge clock);

      $display("covered %0d events and %0d results over seven register settings,",
               events_done, results_done);
      $display("including discovery off, clamped extremes and a saturated loss streak");
      if (errors == 0 && result_queue.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         if (result_queue.size() != 0)
            $error("%0d results never arrived", result_queue.size());
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/pmtud_pkg.sv
rtl/core/pmtud_chan_if.sv
rtl/core/pmtud_step.sv
rtl/core/path_mtu_discovery_controller.sv
sim/tb_path_mtu_discovery_controller.sv
